// ===== design/uvs_pkg.sv =====
// Shared constants, types and fixed-point helpers for the UV sphere vertex generator.
`default_nettype none
package uvs_pkg;

   localparam int IDX_W      = 9;
   localparam int CNT_W      = 9;
   localparam int RADIUS_W   = 16;
   localparam int POS_W      = 17;
   localparam int NRM_W      = 16;
   localparam int TEX_W      = 17;
   localparam int CORNER_W   = 17;
   localparam int PHASE_W    = 32;
   localparam int Q30_W      = 31;
   localparam int FRAC_BITS  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_SECTORS = 256;
   localparam int MAX_STACKS  = 256;

   localparam int DIV_STEPS     = IDX_W + FRAC_BITS;
   localparam int DIV_PER_STAGE = 6;
   localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam int DIV_TAP16     = IDX_W + 16 - 1;
   localparam int DIV_TAP31     = IDX_W + 31 - 1;
   localparam int SINE_STAGES   = 6;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
   localparam logic [CNT_W-1:0]    COUNT_RESET  = 9'd200;
   localparam logic [TEX_W-1:0]    TEX_MAX      = 17'h10000;

   localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [Q30_W-1:0] K1 = 31'd1686629713;
   localparam logic [Q30_W-1:0] K3 = 31'd693598669;
   localparam logic [Q30_W-1:0] K5 = 31'd85569306;
   localparam logic [Q30_W-1:0] K7 = 31'd5026995;
   localparam logic [Q30_W-1:0] K9 = 31'd172272;
   localparam logic [Q30_W-1:0] HORNER_K [4] = '{K7, K5, K3, K1};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS,
      CSR_SECTOR_COUNT,
      CSR_STACK_COUNT
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0]     numer;
      logic [CNT_W-1:0]     rem;
      logic [DIV_STEPS-1:0] quot;
      logic [CNT_W-1:0]     rem16;
      logic [CNT_W-1:0]     rem31;
   } div_state_type;

   typedef struct packed {
      logic                quad_valid;
      logic [CORNER_W-1:0] lower;
      logic [CORNER_W-1:0] upper;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      logic [3:0]       neg;
   } carry_type;

   // One restoring step: shift in the next dividend bit, subtract when it fits.
   function automatic div_state_type div_step(div_state_type st, int k,
                                              logic [CNT_W-1:0] d);
      logic [CNT_W:0] trial;
      logic [CNT_W:0] diff;
      logic           take;
      div_state_type  nx;
      trial = {st.rem, st.numer[IDX_W-1]};
      diff  = trial - {1'b0, d};
      take  = trial >= {1'b0, d};
      nx       = st;
      nx.numer = {st.numer[IDX_W-2:0], 1'b0};
      nx.rem   = take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      nx.quot  = {st.quot[DIV_STEPS-2:0], take};
      if (k == DIV_TAP16) nx.rem16 = nx.rem;
      if (k == DIV_TAP31) nx.rem31 = nx.rem;
      return nx;
   endfunction

   function automatic logic [Q30_W-1:0] mul_q30_trunc(logic [Q30_W-1:0] a,
                                                      logic [Q30_W-1:0] b);
      logic [2*Q30_W-1:0] p;
      p = (2*Q30_W)'(a) * (2*Q30_W)'(b);
      return p[2*Q30_W-2:Q30_W-1];
   endfunction

   function automatic logic [Q30_W-1:0] mul_q30_round(logic [Q30_W-1:0] a,
                                                      logic [Q30_W-1:0] b);
      logic [2*Q30_W-1:0] p;
      p = (2*Q30_W)'(a) * (2*Q30_W)'(b) + (2*Q30_W)'(ONE_Q30 >> 1);
      return p[2*Q30_W-2:Q30_W-1];
   endfunction

endpackage
`default_nettype wire

// ===== design/uvs_req_if.sv =====
// Grid point channel: valid/ready handshake with sector and stack indices.
`default_nettype none
interface uvs_req_if;
   logic                      valid;
   logic                      ready;
   logic [uvs_pkg::IDX_W-1:0] sector_index;
   logic [uvs_pkg::IDX_W-1:0] stack_index;

   modport source (output valid, output sector_index, output stack_index, input ready);
   modport sink (input valid, input sector_index, input stack_index, output ready);
endinterface
`default_nettype wire

// ===== design/uvs_rsp_if.sv =====
// Vertex channel: valid/ready handshake with position, normal, texture and quad corners.
`default_nettype none
interface uvs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [uvs_pkg::POS_W-1:0]    pos_x;
   logic signed [uvs_pkg::POS_W-1:0]    pos_y;
   logic signed [uvs_pkg::POS_W-1:0]    pos_z;
   logic signed [uvs_pkg::NRM_W-1:0]    normal_x;
   logic signed [uvs_pkg::NRM_W-1:0]    normal_y;
   logic signed [uvs_pkg::NRM_W-1:0]    normal_z;
   logic [uvs_pkg::TEX_W-1:0]           tex_u;
   logic [uvs_pkg::TEX_W-1:0]           tex_v;
   logic [uvs_pkg::CORNER_W-1:0]        lower_corner_index;
   logic [uvs_pkg::CORNER_W-1:0]        upper_corner_index;
   logic                                quad_valid;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output normal_x, output normal_y, output normal_z,
                   output tex_u, output tex_v, output lower_corner_index,
                   output upper_corner_index, output quad_valid, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z,
                 input normal_x, input normal_y, input normal_z,
                 input tex_u, input tex_v, input lower_corner_index,
                 input upper_corner_index, input quad_valid, output ready);
endinterface
`default_nettype wire

// ===== design/uvs_divider.sv =====
// Pipelined restoring divider: index over count with 32 fraction bits and rounding taps.
`default_nettype none
module uvs_divider (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [uvs_pkg::IDX_W-1:0]     numer,
   input  logic [uvs_pkg::CNT_W-1:0]     divisor,
   output uvs_pkg::div_state_type        result
);
   import uvs_pkg::*;

   div_state_type stage_ff [DIV_STAGES];
   div_state_type stage_in [DIV_STAGES];

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         div_state_type st;
         if (s == 0) begin
            st = '0;
            st.numer = numer;
         end else begin
            st = stage_ff[s-1];
         end
         for (int j = 0; j < DIV_PER_STAGE; j++) begin
            if (s * DIV_PER_STAGE + j < DIV_STEPS) begin
               st = div_step(st, s * DIV_PER_STAGE + j, divisor);
            end
         end
         stage_in[s] = st;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) stage_ff[s] <= stage_in[s];
      end
   end

   assign result = stage_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== design/uvs_sine.sv =====
// Pipelined quarter-wave sine: ninth-order odd polynomial, one Horner product per stage.
`default_nettype none
module uvs_sine (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [uvs_pkg::Q30_W-1:0]     z,
   output logic [uvs_pkg::Q30_W-1:0]     mag
);
   import uvs_pkg::*;

   logic [Q30_W-1:0] z_ff  [5];
   logic [Q30_W-1:0] z_in  [5];
   logic [Q30_W-1:0] z2_ff [4];
   logic [Q30_W-1:0] z2_in [4];
   logic [Q30_W-1:0] s_ff  [5];
   logic [Q30_W-1:0] s_in  [5];
   logic [Q30_W-1:0] prod;
   logic [Q30_W-1:0] mag_in;
   logic [Q30_W-1:0] mag_ff;

   always_comb begin
      z_in[0]  = z;
      z2_in[0] = mul_q30_trunc(z, z);
      s_in[0]  = K9;
      for (int i = 1; i < 5; i++) begin
         z_in[i] = z_ff[i-1];
         s_in[i] = HORNER_K[i-1] - mul_q30_trunc(s_ff[i-1], z2_ff[i-1]);
         if (i < 4) z2_in[i] = z2_ff[i-1];
      end
      prod   = mul_q30_trunc(s_ff[4], z_ff[4]);
      mag_in = (prod > ONE_Q30) ? ONE_Q30 : prod;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 5; i++) begin
            z_ff[i] <= z_in[i];
            s_ff[i] <= s_in[i];
         end
         for (int i = 0; i < 4; i++) z2_ff[i] <= z2_in[i];
         mag_ff <= mag_in;
      end
   end

   assign mag = mag_ff;

endmodule
`default_nettype wire

// ===== design/uv_sphere_vertex_generator_unit.sv =====
// UV sphere vertex generator: one grid point in, one vertex out.
// Pipeline: 7 divider stages, phase, fold, 6 sine stages, normal, scale, output,
// registered in that order from an accepted request beat to its response beat.
// Throughput: one beat per cycle; the whole pipe holds while the output beat waits.
// Reset: synchronous, clears all valid bits and loads radius 1.0 and counts of 200.
`default_nettype none
module uv_sphere_vertex_generator_unit (
   input  logic                              clock,
   input  logic                              reset,
   uvs_req_if.sink                           req,
   uvs_rsp_if.source                         rsp,
   input  logic                              csr_wr_en,
   input  logic [uvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [uvs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import uvs_pkg::*;

   logic                advance;
   logic [RADIUS_W-1:0] radius_ff;
   logic [CNT_W-1:0]    sectors_ff;
   logic [CNT_W-1:0]    stacks_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    stack_count_in;

   // entry
   side_type            side_in;
   logic [CNT_W:0]      sectors_p1;
   logic [2*CNT_W:0]    row_base;
   side_type            side_ff [DIV_STAGES];
   logic                div_valid_ff [DIV_STAGES];
   div_state_type       div_x;
   div_state_type       div_y;

   // phase
   logic [CNT_W-1:0]    half_s;
   logic [CNT_W-1:0]    half_t;
   logic [CNT_W:0]      rsum_u16, rsum_u32, rsum_v16, rsum_v31;
   logic [PHASE_W-1:0]  lon_in, lat_in, lon_ff, lat_ff;
   logic [TEX_W-1:0]    tex_u_in, tex_v_in;
   carry_type           ph_carry_ff;
   logic                ph_valid_ff;

   // fold
   logic [PHASE_W-1:0]  fold_phase [4];
   logic [1:0]          quad [4];
   logic [Q30_W-1:0]    z_in [4];
   logic [Q30_W-1:0]    z_ff [4];
   carry_type           fold_carry_in;
   carry_type           fold_carry_ff;
   logic                fold_valid_ff;

   // sine
   logic [Q30_W-1:0]    sine_mag [4];
   carry_type           sine_carry_ff [SINE_STAGES];
   logic                sine_valid_ff [SINE_STAGES];

   // normal
   logic [3:0]          sneg;
   logic [Q30_W-1:0]    nmag_in [3];
   logic [2:0]          nneg_in;
   logic [Q30_W-1:0]    nmag_ff [3];
   logic [2:0]          nneg_ff;
   carry_type           nrm_carry_ff;
   logic                nrm_valid_ff;

   // scale
   logic [RADIUS_W+Q30_W-1:0] pprod [3];
   logic [Q30_W-1:0]          mround [3];
   logic [POS_W-1:0]          pmag_ff [3];
   logic [NRM_W-2:0]          mmag_ff [3];
   logic [2:0]                fneg_ff;
   carry_type                 fix_carry_ff;
   logic                      fix_valid_ff;

   // output
   logic signed [POS_W-1:0]   pos_in  [3];
   logic signed [NRM_W-1:0]   nrm_in  [3];
   logic signed [POS_W-1:0]   pos_ff  [3];
   logic signed [NRM_W-1:0]   nrm_ff  [3];
   carry_type                 out_carry_ff;
   logic                      out_valid_ff;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // configuration: store the effective counts directly
   always_comb begin
      if (csr_wdata[CNT_W-1:0] == '0) begin
         count_in = CNT_W'(1);
      end else if (csr_wdata[CNT_W-1:0] > CNT_W'(MAX_SECTORS)) begin
         count_in = CNT_W'(MAX_SECTORS);
      end else begin
         count_in = csr_wdata[CNT_W-1:0];
      end
      if (csr_wdata[CNT_W-1:0] == '0) begin
         stack_count_in = CNT_W'(1);
      end else if (csr_wdata[CNT_W-1:0] > CNT_W'(MAX_STACKS)) begin
         stack_count_in = CNT_W'(MAX_STACKS);
      end else begin
         stack_count_in = csr_wdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RESET;
         sectors_ff <= COUNT_RESET;
         stacks_ff  <= COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RADIUS:       radius_ff  <= csr_wdata[RADIUS_W-1:0];
            CSR_SECTOR_COUNT: sectors_ff <= count_in;
            CSR_STACK_COUNT:  stacks_ff  <= stack_count_in;
            default: ;
         endcase
      end
   end

   // entry: quad corners alongside the dividers
   always_comb begin
      sectors_p1 = {1'b0, sectors_ff} + (CNT_W+1)'(1);
      row_base   = (2*CNT_W+1)'(req.stack_index) * (2*CNT_W+1)'(sectors_p1)
                 + (2*CNT_W+1)'(req.sector_index);
      side_in.quad_valid = (req.sector_index < sectors_ff) && (req.stack_index < stacks_ff);
      side_in.lower = side_in.quad_valid ? row_base[CORNER_W-1:0] : '0;
      side_in.upper = side_in.quad_valid ?
                      row_base[CORNER_W-1:0] + CORNER_W'(sectors_p1) : '0;
   end

   uvs_divider u_div_x (
      .clock   (clock),
      .advance (advance),
      .numer   (req.sector_index),
      .divisor (sectors_ff),
      .result  (div_x)
   );

   uvs_divider u_div_y (
      .clock   (clock),
      .advance (advance),
      .numer   (req.stack_index),
      .divisor (stacks_ff),
      .result  (div_y)
   );

   // phase: round the quotients, saturate texture coordinates
   always_comb begin
      half_s   = sectors_ff >> 1;
      half_t   = stacks_ff >> 1;
      rsum_u16 = {1'b0, div_x.rem16} + {1'b0, half_s};
      rsum_u32 = {1'b0, div_x.rem}   + {1'b0, half_s};
      rsum_v16 = {1'b0, div_y.rem16} + {1'b0, half_t};
      rsum_v31 = {1'b0, div_y.rem31} + {1'b0, half_t};
      lon_in = div_x.quot[FRAC_BITS-1:0]
             + PHASE_W'(rsum_u32 >= {1'b0, sectors_ff});
      lat_in = {div_y.quot[FRAC_BITS], div_y.quot[FRAC_BITS-1:1]}
             + PHASE_W'(rsum_v31 >= {1'b0, stacks_ff});
      if (div_x.quot[DIV_STEPS-1:FRAC_BITS] != '0) begin
         tex_u_in = TEX_MAX;
      end else begin
         tex_u_in = TEX_W'(div_x.quot[FRAC_BITS-1:FRAC_BITS-16])
                  + TEX_W'(rsum_u16 >= {1'b0, sectors_ff});
      end
      if (div_y.quot[DIV_STEPS-1:FRAC_BITS] != '0) begin
         tex_v_in = TEX_MAX;
      end else begin
         tex_v_in = TEX_W'(div_y.quot[FRAC_BITS-1:FRAC_BITS-16])
                  + TEX_W'(rsum_v16 >= {1'b0, stacks_ff});
      end
   end

   // fold: sin and cos of longitude, sin and cos of colatitude
   always_comb begin
      fold_phase[0] = lon_ff;
      fold_phase[1] = lon_ff;
      fold_phase[2] = lat_ff;
      fold_phase[3] = lat_ff;
      fold_carry_in = ph_carry_ff;
      for (int i = 0; i < 4; i++) begin
         // cosine is a quarter turn ahead
         quad[i] = fold_phase[i][PHASE_W-1:PHASE_W-2] + 2'(i % 2);
         z_in[i] = quad[i][0] ?
                   ONE_Q30 - {1'b0, fold_phase[i][PHASE_W-3:0]} :
                   {1'b0, fold_phase[i][PHASE_W-3:0]};
         fold_carry_in.neg[i] = quad[i][1];
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_sine
      uvs_sine u_sine (
         .clock   (clock),
         .advance (advance),
         .z       (z_ff[g]),
         .mag     (sine_mag[g])
      );
   end

   // normal: combine the trig terms
   always_comb begin
      carry_type c;
      c = sine_carry_ff[SINE_STAGES-1];
      for (int i = 0; i < 4; i++) sneg[i] = c.neg[i] && (sine_mag[i] != '0);
      nmag_in[0] = mul_q30_round(sine_mag[1], sine_mag[2]);
      nneg_in[0] = (sneg[1] != sneg[2]) && (nmag_in[0] != '0);
      nmag_in[1] = sine_mag[3];
      nneg_in[1] = sneg[3];
      nmag_in[2] = mul_q30_round(sine_mag[0], sine_mag[2]);
      nneg_in[2] = (sneg[0] != sneg[2]) && (nmag_in[2] != '0);
   end

   // scale and encode
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pprod[k]  = (RADIUS_W+Q30_W)'(radius_ff) * (RADIUS_W+Q30_W)'(nmag_ff[k])
                   + (RADIUS_W+Q30_W)'(ONE_Q30 >> 1);
         mround[k] = nmag_ff[k] + Q30_W'(32'h8000);
         pos_in[k] = (fneg_ff[k] && pmag_ff[k] != '0) ?
                     -$signed(pmag_ff[k]) : $signed(pmag_ff[k]);
         nrm_in[k] = (fneg_ff[k] && mmag_ff[k] != '0) ?
                     -$signed({1'b0, mmag_ff[k]}) : $signed({1'b0, mmag_ff[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) div_valid_ff[s] <= 1'b0;
         for (int s = 0; s < SINE_STAGES; s++) sine_valid_ff[s] <= 1'b0;
         ph_valid_ff   <= 1'b0;
         fold_valid_ff <= 1'b0;
         nrm_valid_ff  <= 1'b0;
         fix_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= req.valid;
         for (int s = 1; s < DIV_STAGES; s++) div_valid_ff[s] <= div_valid_ff[s-1];
         ph_valid_ff      <= div_valid_ff[DIV_STAGES-1];
         fold_valid_ff    <= ph_valid_ff;
         sine_valid_ff[0] <= fold_valid_ff;
         for (int s = 1; s < SINE_STAGES; s++) sine_valid_ff[s] <= sine_valid_ff[s-1];
         nrm_valid_ff <= sine_valid_ff[SINE_STAGES-1];
         fix_valid_ff <= nrm_valid_ff;
         out_valid_ff <= fix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < DIV_STAGES; s++) side_ff[s] <= side_ff[s-1];
         lon_ff            <= lon_in;
         lat_ff            <= lat_in;
         ph_carry_ff.side  <= side_ff[DIV_STAGES-1];
         ph_carry_ff.tex_u <= tex_u_in;
         ph_carry_ff.tex_v <= tex_v_in;
         ph_carry_ff.neg   <= '0;
         for (int i = 0; i < 4; i++) z_ff[i] <= z_in[i];
         fold_carry_ff    <= fold_carry_in;
         sine_carry_ff[0] <= fold_carry_ff;
         for (int s = 1; s < SINE_STAGES; s++) sine_carry_ff[s] <= sine_carry_ff[s-1];
         for (int k = 0; k < 3; k++) nmag_ff[k] <= nmag_in[k];
         nneg_ff      <= nneg_in;
         nrm_carry_ff <= sine_carry_ff[SINE_STAGES-1];
         for (int k = 0; k < 3; k++) begin
            pmag_ff[k] <= pprod[k][RADIUS_W+Q30_W-1:Q30_W-1];
            mmag_ff[k] <= mround[k][Q30_W-1:16];
         end
         fneg_ff      <= nneg_ff;
         fix_carry_ff <= nrm_carry_ff;
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= pos_in[k];
            nrm_ff[k] <= nrm_in[k];
         end
         out_carry_ff <= fix_carry_ff;
      end
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.pos_x              = pos_ff[0];
   assign rsp.pos_y              = pos_ff[1];
   assign rsp.pos_z              = pos_ff[2];
   assign rsp.normal_x           = nrm_ff[0];
   assign rsp.normal_y           = nrm_ff[1];
   assign rsp.normal_z           = nrm_ff[2];
   assign rsp.tex_u              = out_carry_ff.tex_u;
   assign rsp.tex_v              = out_carry_ff.tex_v;
   assign rsp.lower_corner_index = out_carry_ff.side.lower;
   assign rsp.upper_corner_index = out_carry_ff.side.upper;
   assign rsp.quad_valid         = out_carry_ff.side.quad_valid;

endmodule
`default_nettype wire

// ===== test/uvs_vertex_checker.sv =====
// Vertex checker: watches both channels, predicts each vertex and compares it.
`timescale 1ns / 100ps
module uvs_vertex_checker (
   input  logic  clock,
   input  logic  reset,
   uvs_req_if    req,
   uvs_rsp_if    rsp,
   input  logic                            csr_wr_en,
   input  logic [uvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [uvs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int    failures,
   output int    pending,
   output int    vertices_checked
);
   import uvs_pkg::*;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   typedef struct {
      logic [63:0] mag;
      bit          neg;
   } sign_mag_type;

   typedef struct {
      logic signed [POS_W-1:0] pos [3];
      logic signed [NRM_W-1:0] nrm [3];
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
      logic [CORNER_W-1:0]     lower;
      logic [CORNER_W-1:0]     upper;
      logic                    quad_valid;
   } vertex_type;

   logic [RADIUS_W-1:0] radius_q;
   logic [CNT_W-1:0]    sectors_q;
   logic [CNT_W-1:0]    stacks_q;
   vertex_type          vertex_queue [$];

   function automatic logic [63:0] quarter_wave_sine(logic [63:0] z);
      logic [63:0] z2;
      logic [63:0] s;
      z2 = (z * z) >> 30;
      s  = 64'd172272;
      s  = 64'd5026995 - ((s * z2) >> 30);
      s  = 64'd85569306 - ((s * z2) >> 30);
      s  = 64'd693598669 - ((s * z2) >> 30);
      s  = 64'd1686629713 - ((s * z2) >> 30);
      s  = (s * z) >> 30;
      return (s > Q30_ONE) ? Q30_ONE : s;
   endfunction

   function automatic sign_mag_type sine_of_phase(logic [31:0] ph);
      sign_mag_type r;
      logic [63:0]  z;
      z = {34'd0, ph[29:0]};
      if (ph[30]) z = Q30_ONE - z;
      r.mag = quarter_wave_sine(z);
      r.neg = ph[31] && (r.mag != 0);
      return r;
   endfunction

   function automatic sign_mag_type product_q30(sign_mag_type a, sign_mag_type b);
      sign_mag_type r;
      r.mag = (a.mag * b.mag + (Q30_ONE >> 1)) >> 30;
      r.neg = (a.neg != b.neg) && (r.mag != 0);
      return r;
   endfunction

   function automatic logic [63:0] apply_sign(logic [63:0] mag, bit neg);
      return (neg && mag != 0) ? (64'd0 - mag) : mag;
   endfunction

   function automatic logic [63:0] clamp_count(logic [CNT_W-1:0] c, int max_c);
      if (c == 0) return 64'd1;
      return (c > max_c) ? 64'(max_c) : 64'(c);
   endfunction

   function automatic logic [63:0] tex_ratio(logic [63:0] i, logic [63:0] n);
      logic [63:0] t;
      t = ((i << 16) + (n >> 1)) / n;
      return (t > 64'd65536) ? 64'd65536 : t;
   endfunction

   function automatic vertex_type predict_vertex(logic [IDX_W-1:0] sec,
                                                 logic [IDX_W-1:0] stk);
      vertex_type   v;
      logic [63:0]  s_cnt, t_cnt, x, y, p, m;
      logic [31:0]  lon, lat;
      sign_mag_type sin_t, cos_t, sin_p, cos_p;
      sign_mag_type n [3];
      x     = 64'(sec);
      y     = 64'(stk);
      s_cnt = clamp_count(sectors_q, MAX_SECTORS);
      t_cnt = clamp_count(stacks_q, MAX_STACKS);
      lon   = 32'(((x << 32) + (s_cnt >> 1)) / s_cnt);
      lat   = 32'(((y << 31) + (t_cnt >> 1)) / t_cnt);
      sin_t = sine_of_phase(lon);
      cos_t = sine_of_phase(lon + 32'h4000_0000);
      sin_p = sine_of_phase(lat);
      cos_p = sine_of_phase(lat + 32'h4000_0000);
      n[0]  = product_q30(cos_t, sin_p);
      n[1]  = cos_p;
      n[2]  = product_q30(sin_t, sin_p);
      for (int k = 0; k < 3; k++) begin
         p = (64'(radius_q) * n[k].mag + (Q30_ONE >> 1)) >> 30;
         m = (n[k].mag + (64'd1 << 15)) >> 16;
         v.pos[k] = POS_W'(apply_sign(p, n[k].neg));
         v.nrm[k] = NRM_W'(apply_sign(m, n[k].neg));
      end
      v.tex_u      = TEX_W'(tex_ratio(x, s_cnt));
      v.tex_v      = TEX_W'(tex_ratio(y, t_cnt));
      v.quad_valid = (x < s_cnt) && (y < t_cnt);
      v.lower      = v.quad_valid ? CORNER_W'(y * (s_cnt + 1) + x) : '0;
      v.upper      = v.quad_valid ? CORNER_W'((y + 1) * (s_cnt + 1) + x) : '0;
      return v;
   endfunction

   function automatic int compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      vertex_type want;
      int         bad;
      if (reset) begin
         radius_q         <= RADIUS_RESET;
         sectors_q        <= COUNT_RESET;
         stacks_q         <= COUNT_RESET;
         vertex_queue.delete();
         failures         <= 0;
         pending          <= 0;
         vertices_checked <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RADIUS:       radius_q  <= csr_wdata[RADIUS_W-1:0];
               CSR_SECTOR_COUNT: sectors_q <= csr_wdata[CNT_W-1:0];
               CSR_STACK_COUNT:  stacks_q  <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         bad = 0;
         if (rsp.valid && rsp.ready) begin
            if (vertex_queue.size() == 0) begin
               $error("vertex beat with no grid point outstanding");
               bad = 1;
            end else begin
               want = vertex_queue.pop_front();
               bad += compare_field("pos_x", want.pos[0], rsp.pos_x);
               bad += compare_field("pos_y", want.pos[1], rsp.pos_y);
               bad += compare_field("pos_z", want.pos[2], rsp.pos_z);
               bad += compare_field("normal_x", want.nrm[0], rsp.normal_x);
               bad += compare_field("normal_y", want.nrm[1], rsp.normal_y);
               bad += compare_field("normal_z", want.nrm[2], rsp.normal_z);
               bad += compare_field("tex_u", want.tex_u, rsp.tex_u);
               bad += compare_field("tex_v", want.tex_v, rsp.tex_v);
               bad += compare_field("lower_corner_index", want.lower, rsp.lower_corner_index);
               bad += compare_field("upper_corner_index", want.upper, rsp.upper_corner_index);
               bad += compare_field("quad_valid", want.quad_valid, rsp.quad_valid);
            end
            vertices_checked <= vertices_checked + 1;
         end
         if (req.valid && req.ready)
            vertex_queue.insert(vertex_queue.size(),
                                predict_vertex(req.sector_index, req.stack_index));
         failures <= failures + bad;
         pending  <= vertex_queue.size();
      end
   end

endmodule

// ===== test/tb_uv_sphere_vertex_generator_unit.sv =====
// Testbench top: clock, reset, grid point stimulus, register phases and verdict.
`timescale 1ns / 100ps
module tb_uv_sphere_vertex_generator_unit;
   import uvs_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    failures;
   int                    pending;
   int                    vertices_checked;
   int                    sender_idle_pct;
   int                    receiver_stall_pct;
   int                    hold_seq;
   int                    hold_seen;
   int                    hold_left;
   int                    points_sent;

   uvs_req_if req ();
   uvs_rsp_if rsp ();

   uv_sphere_vertex_generator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   uvs_vertex_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .pending          (pending),
      .vertices_checked (vertices_checked)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Receiver: a long hold-off when requested, otherwise random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= 300;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_point(input logic [IDX_W-1:0] sec, input logic [IDX_W-1:0] stk);
      req.valid        <= 1'b1;
      req.sector_index <= sec;
      req.stack_index  <= stk;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      points_sent++;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Hold the sender until every vertex is back, then let the pipe settle.
   task automatic drain;
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_sphere(input logic [15:0] rad, input logic [8:0] sec, input logic [8:0] stk);
      write_csr(CSR_RADIUS, rad);
      write_csr(CSR_SECTOR_COUNT, CSR_DATA_W'(sec));
      write_csr(CSR_STACK_COUNT, CSR_DATA_W'(stk));
   endtask

   function automatic int effective_count(logic [8:0] c);
      if (c == 0) return 1;
      return (c > 256) ? 256 : c;
   endfunction

   function automatic logic [IDX_W-1:0] pick_index(int cnt);
      if ($urandom_range(99) < 80) return IDX_W'($urandom_range(0, cnt));
      return IDX_W'($urandom_range(0, 511));
   endfunction

   initial begin
      logic [15:0] radii  [8] = '{16'd256, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'h8000, 16'd0, 16'd300};
      logic [8:0]  sects  [8] = '{9'd200, 9'd0, 9'd511, 9'd256, 9'd1, 9'd3, 9'd0, 9'd7};
      logic [8:0]  stacks [8] = '{9'd200, 9'd0, 9'd511, 9'd256, 9'd1, 9'd2, 9'd0, 9'd5};
      int          idles  [8] = '{0, 75, 0, 14, 0, 75, 0, 14};
      int          stalls [8] = '{0, 0, 75, 14, 0, 0, 75, 14};
      int          s_eff;
      int          t_eff;
      reset              = 1'b1;
      req.valid          = 1'b0;
      req.sector_index   = '0;
      req.stack_index    = '0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_RADIUS;
      csr_wdata          = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_seq           = 0;
      points_sent        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: poles, seam, last quad, indices past the count.
      send_point(0, 0);
      send_point(200, 200);
      send_point(199, 199);
      send_point(100, 50);
      send_point(50, 100);
      send_point(1, 0);
      send_point(0, 1);
      send_point(170, 85);
      send_point(200, 0);
      send_point(0, 200);
      send_point(201, 0);
      send_point(0, 201);
      send_point(256, 256);
      send_point(511, 511);
      send_point(511, 0);
      send_point(0, 511);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 6) begin
            radii[6]  = 16'($urandom_range(0, 65535));
            sects[6]  = 9'($urandom_range(1, 511));
            stacks[6] = 9'($urandom_range(1, 511));
         end
         load_sphere(radii[ph], sects[ph], stacks[ph]);
         sender_idle_pct    = idles[ph];
         receiver_stall_pct = stalls[ph];
         s_eff = effective_count(sects[ph]);
         t_eff = effective_count(stacks[ph]);
         // Zero radius and clamped counts get their edges exercised directly.
         if (ph == 1 || ph == 2) begin
            send_point(0, 0);
            send_point(IDX_W'(s_eff), IDX_W'(t_eff));
            send_point(511, 511);
         end
         if (ph == 4) hold_seq <= hold_seq + 1;
         for (int i = 0; i < 200; i++)
            send_point(pick_index(s_eff), pick_index(t_eff));
         drain();
      end

      $display("covered %0d grid points over 9 register settings: zero radius, clamped counts,",
               points_sent);
      $display("indices past the count, pole and seam points, stalls and a long output hold-off");
      if (failures == 0 && vertices_checked == points_sent) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/uvs_pkg.sv
design/uvs_req_if.sv
design/uvs_rsp_if.sv
design/uvs_divider.sv
design/uvs_sine.sv
design/uv_sphere_vertex_generator_unit.sv
test/uvs_vertex_checker.sv
test/tb_uv_sphere_vertex_generator_unit.sv
